>>> design/khm_pkg.sv
// Shared types and constants for the keyed MAC hash table matcher.
package khm_pkg;

	// Hash chain constants.
	localparam logic [31:0] HASH_MUL   = 32'hc6b0_77eb;
	localparam logic [31:0] FLAG_STEP  = 32'hdae1_011d;
	localparam int unsigned FLAG_SHIFT = 5;

	// Field widths fixed by the interface.
	localparam int unsigned SLOT_W  = 4;
	localparam int unsigned SLOT_SPAN = 2 ** SLOT_W;
	localparam int unsigned KEY_W   = 16;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned COUNT_W = 5;

	// Queue between the hashing front and the matching back.
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = 2;

	// Item kind on the input port.
	typedef enum logic {
		FUNC_LOAD = 1'b0,
		FUNC_BYTE = 1'b1
	} func_t;

	// Configuration register indexes.
	typedef enum logic {
		REG_HASH_MAGIC = 1'b0,
		REG_KEY_COUNT  = 1'b1
	} cfg_reg_t;

	// Operation carried through the queue.
	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_SEARCH = 1'b1
	} op_t;

	// One queued operation: a key load or a finished hash to look up.
	typedef struct packed {
		op_t               op;
		logic [SLOT_W-1:0] slot;
		logic [KEY_W-1:0]  data;
	} q_entry_t;

endpackage

>>> design/khm_front.sv
// Front end: accepts items, runs the keyed hash chain and queues loads and lookups.
module khm_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         magic_we,
	input  logic [khm_pkg::WORD_W-1:0]   magic_data,
	input  logic                         accept,
	input  logic                         func,
	input  logic [khm_pkg::BYTE_W-1:0]   mac_byte,
	input  logic                         last_byte,
	input  logic [khm_pkg::SLOT_W-1:0]   key_slot,
	input  logic [khm_pkg::KEY_W-1:0]    key_value,
	output logic                         q_push,
	output khm_pkg::q_entry_t            q_entry
);

	logic [khm_pkg::WORD_W-1:0] magic_q;
	logic [khm_pkg::WORD_W-1:0] seed_init_q;
	logic [khm_pkg::WORD_W-1:0] seed_q;
	logic [khm_pkg::WORD_W-1:0] flag_q;
	logic                       mid_q;

	logic [khm_pkg::WORD_W-1:0] seed_cur;
	logic [khm_pkg::WORD_W-1:0] flag_cur;
	logic [khm_pkg::WORD_W-1:0] seed_nxt;
	logic [khm_pkg::WORD_W-1:0] flag_nxt;
	logic                       is_byte;

	// The starting seed depends only on the magic, so it is prepared when the magic is written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q     <= '0;
			seed_init_q <= '0;
		end else if (magic_we) begin
			magic_q     <= magic_data;
			seed_init_q <= magic_data * khm_pkg::HASH_MUL + (magic_data >> khm_pkg::FLAG_SHIFT);
		end
	end

	// One multiply-add step per address byte.
	always_comb begin
		is_byte  = (khm_pkg::func_t'(func) == khm_pkg::FUNC_BYTE);
		flag_cur = mid_q ? flag_q : (magic_q >> khm_pkg::FLAG_SHIFT);
		seed_cur = mid_q ? seed_q : seed_init_q;
		seed_nxt = seed_cur * khm_pkg::HASH_MUL + flag_cur
			+ {{(khm_pkg::WORD_W - khm_pkg::BYTE_W){1'b0}}, mac_byte};
		flag_nxt = flag_cur + khm_pkg::FLAG_STEP;
	end

	// Running chain state; key loads leave it alone.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
			flag_q <= '0;
			mid_q  <= 1'b0;
		end else if (accept && is_byte) begin
			seed_q <= seed_nxt;
			flag_q <= flag_nxt;
			mid_q  <= !last_byte;
		end
	end

	// Key loads and final bytes go to the back end in arrival order.
	always_comb begin
		q_push       = accept && (!is_byte || last_byte);
		q_entry.op   = is_byte ? khm_pkg::OP_SEARCH : khm_pkg::OP_LOAD;
		q_entry.slot = key_slot;
		q_entry.data = is_byte ? seed_nxt[khm_pkg::KEY_W-1:0] : key_value;
	end

endmodule

>>> design/khm_queue.sv
// Short queue of operations between the front and back ends.
module khm_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  khm_pkg::q_entry_t    push_entry,
	output logic                 full,
	output logic                 valid,
	output khm_pkg::q_entry_t    head,
	input  logic                 pop
);

	khm_pkg::q_entry_t             slots_q [khm_pkg::QUEUE_DEPTH];
	logic [khm_pkg::QUEUE_AW-1:0]  wr_ptr_q;
	logic [khm_pkg::QUEUE_AW-1:0]  rd_ptr_q;
	logic [khm_pkg::QUEUE_AW:0]    count_q;

	assign full  = (count_q == (khm_pkg::QUEUE_AW + 1)'(khm_pkg::QUEUE_DEPTH));
	assign valid = (count_q != '0);
	assign head  = slots_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// The fill count never passes the depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (khm_pkg::QUEUE_AW + 1)'(khm_pkg::QUEUE_DEPTH))
		else $error("queue fill count above depth");

	// A push into a full queue only happens together with a pop.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && full) |-> pop)
		else $error("push into full queue");

endmodule

>>> design/khm_back.sv
// Back end: key table, parallel lookup and the result register.
module khm_back #(
	parameter int unsigned TBL_DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          count_we,
	input  logic [khm_pkg::COUNT_W-1:0]   count_data,
	input  logic                          q_valid,
	input  khm_pkg::q_entry_t             q_head,
	output logic                          q_pop,
	output logic                          empty,
	input  logic                          pop,
	output logic [khm_pkg::KEY_W-1:0]     hash_value,
	output logic                          found,
	output logic [khm_pkg::SLOT_W-1:0]    match_slot
);

	logic [khm_pkg::KEY_W-1:0]    key_tbl_q [TBL_DEPTH];
	logic [khm_pkg::COUNT_W-1:0]  key_count_q;
	logic                         out_valid_q;
	logic [khm_pkg::KEY_W-1:0]    hash_q;
	logic                         found_q;
	logic [khm_pkg::SLOT_W-1:0]   slot_q;

	logic                         is_load;
	logic                         take_search;
	logic                         hit;
	logic [khm_pkg::SLOT_W-1:0]   hit_slot;

	// Key count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= '0;
		end else if (count_we) begin
			key_count_q <= count_data;
		end
	end

	// Loads drain at once; lookups wait for room in the result register.
	always_comb begin
		is_load     = (q_head.op == khm_pkg::OP_LOAD);
		q_pop       = q_valid && (is_load || !out_valid_q || pop);
		take_search = q_pop && !is_load;
	end

	// Table writes; slots beyond the table are dropped.
	for (genvar i = 0; i < TBL_DEPTH; i++) begin : g_tbl
		always_ff @(posedge clk) begin
			if (q_pop && is_load && (q_head.slot == khm_pkg::SLOT_W'(i))) begin
				key_tbl_q[i] <= q_head.data;
			end
		end
	end

	// Lowest searched slot whose key equals the hash.
	always_comb begin
		hit      = 1'b0;
		hit_slot = '0;
		for (int i = TBL_DEPTH - 1; i >= 0; i--) begin
			if ((khm_pkg::COUNT_W'(i) < key_count_q) && (key_tbl_q[i] == q_head.data)) begin
				hit      = 1'b1;
				hit_slot = khm_pkg::SLOT_W'(i);
			end
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take_search) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (take_search) begin
			hash_q  <= q_head.data;
			found_q <= hit;
			slot_q  <= hit_slot;
		end
	end

	assign empty      = !out_valid_q;
	assign hash_value = hash_q;
	assign found      = found_q;
	assign match_slot = slot_q;

	// The queue is only drained when it holds something.
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

	// A lookup without a hit reports slot zero.
	a_miss_slot: assert property (@(posedge clk) disable iff (!arst_n)
		take_search |=> (found_q || (slot_q == '0)))
		else $error("miss reported with nonzero slot");

	// A reported hit lies inside the searched range.
	a_hit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && found_q) |-> ({1'b0, slot_q} < key_count_q))
		else $error("hit outside searched slots");

endmodule

>>> design/keyed_mac_hash_table_match_top.sv
// Top level of the keyed MAC hash table matcher.
// Address bytes are hashed at one item per clock while full is low, by one 32-bit constant
// multiply-add per byte in the front end; key loads pass straight through it. Key loads and the
// final byte of each address enter a four-entry queue, and the back end takes one queued item
// per cycle unless a lookup must wait for room in the result register, writing the key table or
// comparing the hash against all searched slots in parallel. A finished hash passes through the
// queue into a one-entry result register, where it waits while the input keeps flowing; full rises
// only when that register and the queue are both held up. Key loads take effect in item order, so a
// load followed by an address always sees the new key. The configuration port is always ready.
module keyed_mac_hash_table_match_top #(
	parameter int unsigned KEY_DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic                          func,
	input  logic [khm_pkg::BYTE_W-1:0]    mac_byte,
	input  logic                          last_byte,
	input  logic [khm_pkg::SLOT_W-1:0]    key_slot,
	input  logic [khm_pkg::KEY_W-1:0]     key_value,
	output logic                          empty,
	input  logic                          pop,
	output logic [khm_pkg::KEY_W-1:0]     hash_value,
	output logic                          found,
	output logic [khm_pkg::SLOT_W-1:0]    match_slot,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [khm_pkg::WORD_W-1:0]    cfg_data
);

	// Only slots reachable through the slot field can ever hold a key.
	localparam int unsigned TBL_DEPTH =
		(KEY_DEPTH < khm_pkg::SLOT_SPAN) ? KEY_DEPTH : khm_pkg::SLOT_SPAN;

	logic               accept;
	logic               magic_we;
	logic               count_we;
	logic               q_push;
	khm_pkg::q_entry_t  q_in;
	logic               q_valid;
	khm_pkg::q_entry_t  q_head;
	logic               q_pop;

	// Register decode.
	assign cfg_ready = 1'b1;
	assign magic_we  = cfg_valid && (khm_pkg::cfg_reg_t'(cfg_index) == khm_pkg::REG_HASH_MAGIC);
	assign count_we  = cfg_valid && (khm_pkg::cfg_reg_t'(cfg_index) == khm_pkg::REG_KEY_COUNT);

	assign accept = push && !full;

	khm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.magic_we   (magic_we),
		.magic_data (cfg_data),
		.accept     (accept),
		.func       (func),
		.mac_byte   (mac_byte),
		.last_byte  (last_byte),
		.key_slot   (key_slot),
		.key_value  (key_value),
		.q_push     (q_push),
		.q_entry    (q_in)
	);

	khm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.full       (full),
		.valid      (q_valid),
		.head       (q_head),
		.pop        (q_pop)
	);

	khm_back #(
		.TBL_DEPTH (TBL_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.count_we   (count_we),
		.count_data (cfg_data[khm_pkg::COUNT_W-1:0]),
		.q_valid    (q_valid),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.empty      (empty),
		.pop        (pop),
		.hash_value (hash_value),
		.found      (found),
		.match_slot (match_slot)
	);

endmodule

>>> verif/khm_checker.sv
// Checker for the keyed MAC hash table matcher: predicts each lookup and compares the results.
`timescale 1ns / 1ps

module khm_checker #(
	parameter int unsigned KEY_DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic                          full,
	input  logic                          func,
	input  logic [khm_pkg::BYTE_W-1:0]    mac_byte,
	input  logic                          last_byte,
	input  logic [khm_pkg::SLOT_W-1:0]    key_slot,
	input  logic [khm_pkg::KEY_W-1:0]     key_value,
	input  logic                          empty,
	input  logic                          pop,
	input  logic [khm_pkg::KEY_W-1:0]     hash_value,
	input  logic                          found,
	input  logic [khm_pkg::SLOT_W-1:0]    match_slot,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [khm_pkg::WORD_W-1:0]    cfg_data,
	output int                            fail_count,
	output int                            pending
);

	// One predicted lookup outcome.
	typedef struct packed {
		logic [khm_pkg::KEY_W-1:0]  hash;
		logic                       hit;
		logic [khm_pkg::SLOT_W-1:0] slot;
	} lookup_t;

	// Shadow copy of the registers, the hash chain and the key store.
	logic [khm_pkg::WORD_W-1:0]  magic;
	logic [khm_pkg::COUNT_W-1:0] key_count;
	logic [khm_pkg::WORD_W-1:0]  seed;
	logic [khm_pkg::WORD_W-1:0]  flag;
	logic                        mid_address;
	logic [khm_pkg::KEY_W-1:0]   key_store [KEY_DEPTH];
	lookup_t                     lookup_q [$];
	int                          errors = 0;

	// Track every accepted item, register write and result at the clock edge.
	always @(posedge clk or negedge arst_n) begin : track
		lookup_t     want;
		int unsigned limit;

		if (!arst_n) begin
			magic = '0;
			key_count = '0;
			seed = '0;
			flag = '0;
			mid_address = 1'b0;
			foreach (key_store[i]) key_store[i] = '0;
			lookup_q.delete();
		end else begin
			// Results leave first; a result never comes out at the edge of its last byte.
			if (pop && !empty) begin
				if (lookup_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, actual hash %h found %b slot %0d",
						$time, hash_value, found, match_slot);
				end else begin
					want = lookup_q.pop_front();
					if (hash_value !== want.hash) begin
						errors++;
						$display("%0t: hash_value expected %h actual %h",
							$time, want.hash, hash_value);
					end
					if (found !== want.hit) begin
						errors++;
						$display("%0t: found expected %b actual %b", $time, want.hit, found);
					end
					if (match_slot !== want.slot) begin
						errors++;
						$display("%0t: match_slot expected %0d actual %0d",
							$time, want.slot, match_slot);
					end
				end
			end

			// Register writes.
			if (cfg_valid && cfg_ready) begin
				unique case (khm_pkg::cfg_reg_t'(cfg_index))
					khm_pkg::REG_HASH_MAGIC: magic = cfg_data;
					khm_pkg::REG_KEY_COUNT:  key_count = cfg_data[khm_pkg::COUNT_W-1:0];
					default: ;
				endcase
			end

			// Input items: key loads update the store, address bytes advance the chain.
			if (push && !full) begin
				if (khm_pkg::func_t'(func) == khm_pkg::FUNC_LOAD) begin
					if (key_slot < KEY_DEPTH) key_store[key_slot] = key_value;
				end else begin
					// The magic value is sampled only at the first byte of an address.
					if (!mid_address) begin
						flag = magic >> khm_pkg::FLAG_SHIFT;
						seed = magic * khm_pkg::HASH_MUL + flag;
					end
					seed = seed * khm_pkg::HASH_MUL + flag + khm_pkg::WORD_W'(mac_byte);
					flag = flag + khm_pkg::FLAG_STEP;
					if (!last_byte) begin
						mid_address = 1'b1;
					end else begin
						mid_address = 1'b0;
						want.hash = seed[khm_pkg::KEY_W-1:0];
						want.hit = 1'b0;
						want.slot = '0;
						limit = (key_count > KEY_DEPTH) ? KEY_DEPTH : key_count;
						// Lowest matching slot wins.
						for (int i = 0; i < limit; i++) begin
							if (!want.hit && key_store[i] == want.hash) begin
								want.hit = 1'b1;
								want.slot = khm_pkg::SLOT_W'(i);
							end
						end
						lookup_q.push_back(want);
					end
				end
			end
		end
		fail_count <= errors;
		pending <= lookup_q.size();
	end

endmodule

>>> verif/tb_keyed_mac_hash_table_match_top.sv
// Testbench top for the keyed MAC hash table matcher: drives stimulus and reports the verdict.
`timescale 1ns / 1ps

module tb_keyed_mac_hash_table_match_top;

	localparam int unsigned KEY_DEPTH     = 16;
	localparam int          IDLE_LIMIT    = 1000;
	localparam int          SETTLE_CYCLES = 8;
	localparam int          PHASE_ITEMS   = 80;
	localparam int          PHASE_COUNT   = 6;
	localparam int          POOL_SIZE     = 16;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          push;
	logic                          full;
	logic                          func;
	logic [khm_pkg::BYTE_W-1:0]    mac_byte;
	logic                          last_byte;
	logic [khm_pkg::SLOT_W-1:0]    key_slot;
	logic [khm_pkg::KEY_W-1:0]     key_value;
	logic                          empty;
	logic                          pop = 1'b0;
	logic [khm_pkg::KEY_W-1:0]     hash_value;
	logic                          found;
	logic [khm_pkg::SLOT_W-1:0]    match_slot;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic                          cfg_index;
	logic [khm_pkg::WORD_W-1:0]    cfg_data;
	int                            fail_count;
	int                            pending;

	int                            items_sent = 0;
	int                            idle_cycles = 0;
	int                            pop_stall = 0;
	logic                          calm;
	logic [khm_pkg::KEY_W-1:0]     seen_hash [$];
	logic [63:0]                   addr_pool [$];
	int                            addr_len_pool [$];

	keyed_mac_hash_table_match_top #(.KEY_DEPTH(KEY_DEPTH)) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.func       (func),
		.mac_byte   (mac_byte),
		.last_byte  (last_byte),
		.key_slot   (key_slot),
		.key_value  (key_value),
		.empty      (empty),
		.pop        (pop),
		.hash_value (hash_value),
		.found      (found),
		.match_slot (match_slot),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	khm_checker #(.KEY_DEPTH(KEY_DEPTH)) u_checker (.*);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// A stretch of items in the middle runs with neither side idling.
	assign calm = (items_sent >= 150) && (items_sent < 260);

	// Result side: random stalls, and a record of recent hashes to build matching keys from.
	always @(posedge clk) begin
		if (pop && !empty) begin
			seen_hash.push_back(hash_value);
			if (seen_hash.size() > POOL_SIZE) void'(seen_hash.pop_front());
		end
		if (pop_stall > 0) pop_stall--;
		else if (!calm && $urandom_range(99) < 2) pop_stall = $urandom_range(8, 1);
		pop <= (pop_stall == 0);
	end

	// Watchdog on cycles in which no channel moves an item.
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: watchdog expired after %0d idle cycles", $time, idle_cycles);
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Offer one item, with an occasional gap before it, and wait until it is taken.
	task automatic send_item(input khm_pkg::func_t f, input logic [khm_pkg::BYTE_W-1:0] b,
		input logic l, input logic [khm_pkg::SLOT_W-1:0] s,
		input logic [khm_pkg::KEY_W-1:0] v);
		int gap;

		gap = (!calm && $urandom_range(99) < 4) ? $urandom_range(4, 1) : 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		func <= f;
		mac_byte <= b;
		last_byte <= l;
		key_slot <= s;
		key_value <= v;
		@(posedge clk);
		while (full) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_byte(input logic [khm_pkg::BYTE_W-1:0] b, input logic l);
		send_item(khm_pkg::FUNC_BYTE, b, l, khm_pkg::SLOT_W'($urandom),
			khm_pkg::KEY_W'($urandom));
	endtask

	task automatic send_key(input logic [khm_pkg::SLOT_W-1:0] s,
		input logic [khm_pkg::KEY_W-1:0] v);
		send_item(khm_pkg::FUNC_LOAD, khm_pkg::BYTE_W'($urandom), 1'($urandom), s, v);
	endtask

	// Key value that often equals a recently seen hash, so that lookups hit.
	function automatic logic [khm_pkg::KEY_W-1:0] pick_key();
		if (seen_hash.size() > 0 && $urandom_range(1) == 1)
			return seen_hash[$urandom_range(seen_hash.size() - 1)];
		return khm_pkg::KEY_W'($urandom);
	endfunction

	// Send an address, first byte in the low bits; now and then a key load lands inside it.
	task automatic send_address(input logic [63:0] bytes, input int len);
		for (int i = 0; i < len; i++) begin
			send_byte(bytes[8*i +: 8], i == len - 1);
			if (i < len - 1 && $urandom_range(99) < 5)
				send_key(khm_pkg::SLOT_W'($urandom), pick_key());
		end
	endtask

	// Wait until every expected result is out and any trailing key load has settled.
	task automatic drain();
		push <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input khm_pkg::cfg_reg_t r, input logic [khm_pkg::WORD_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin : stimulus
		logic [khm_pkg::KEY_W-1:0]  h;
		logic [khm_pkg::WORD_W-1:0] d;
		logic [63:0]                bytes;
		int                         start;
		int                         r;
		int                         idx;
		int                         len;

		arst_n = 1'b0;
		push = 1'b0;
		func = khm_pkg::FUNC_LOAD;
		mac_byte = '0;
		last_byte = 1'b0;
		key_slot = '0;
		key_value = '0;
		cfg_valid = 1'b0;
		cfg_index = khm_pkg::REG_HASH_MAGIC;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero key count after reset: single-byte addresses at both byte extremes.
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		drain();
		write_reg(khm_pkg::REG_HASH_MAGIC, 32'hFFFF_FFFF);
		send_address(64'h0000_8001_55AA_FF00, 6);

		// Fill the whole key store before any search may read it.
		for (int s = 0; s < KEY_DEPTH; s++)
			send_key(khm_pkg::SLOT_W'(s), (s == 0) ? 16'h0000 : (s == KEY_DEPTH - 1) ? 16'hFFFF
				: khm_pkg::KEY_W'($urandom));

		// A key load in the middle of an address leaves the chain alone.
		send_byte(8'h5A, 1'b0);
		send_key(4'd9, khm_pkg::KEY_W'($urandom));
		send_byte(8'hA5, 1'b1);
		drain();
		h = seen_hash[$];

		// Same hash in two slots: the lower one must win, and the count bounds the search.
		send_key(4'd7, h);
		send_key(4'd12, h);
		drain();
		write_reg(khm_pkg::REG_KEY_COUNT, 32'd31);
		send_address(64'h0000_0000_0000_A55A, 2);
		drain();
		write_reg(khm_pkg::REG_KEY_COUNT, 32'd8);
		send_address(64'h0000_0000_0000_A55A, 2);
		drain();
		write_reg(khm_pkg::REG_KEY_COUNT, 32'd7);
		send_address(64'h0000_0000_0000_A55A, 2);
		drain();
		write_reg(khm_pkg::REG_KEY_COUNT, 32'd16);
		send_address(64'h0000_0000_0000_A55A, 2);

		// The magic value changes between two bytes of one address.
		send_byte(8'h33, 1'b0);
		drain();
		write_reg(khm_pkg::REG_HASH_MAGIC, 32'h1234_5678);
		send_byte(8'hCC, 1'b1);
		drain();
		write_reg(khm_pkg::REG_KEY_COUNT, 32'd0);
		send_address(64'h0000_0000_0000_A55A, 2);

		// Random phases, each with its own magic value and key count.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			drain();
			unique case (p)
				0: d = 32'h0000_0000;
				1: d = 32'hFFFF_FFFF;
				default: d = $urandom;
			endcase
			write_reg(khm_pkg::REG_HASH_MAGIC, d);
			d = $urandom;
			unique case (p)
				0: d[khm_pkg::COUNT_W-1:0] = 5'd16;
				1: d[khm_pkg::COUNT_W-1:0] = 5'd31;
				2: d[khm_pkg::COUNT_W-1:0] = 5'd1;
				3: d[khm_pkg::COUNT_W-1:0] = khm_pkg::COUNT_W'($urandom_range(15, 2));
				4: d[khm_pkg::COUNT_W-1:0] = khm_pkg::COUNT_W'($urandom_range(30, 17));
				default: ;
			endcase
			write_reg(khm_pkg::REG_KEY_COUNT, d);
			seen_hash.delete();
			addr_pool.delete();
			addr_len_pool.delete();

			start = items_sent;
			while (items_sent - start < PHASE_ITEMS) begin
				r = $urandom_range(99);
				if (r < 15) begin
					send_key(khm_pkg::SLOT_W'($urandom), pick_key());
				end else if (r < 55 && addr_pool.size() > 0) begin
					// Repeat an earlier address so its hash can hit a loaded key.
					idx = $urandom_range(addr_pool.size() - 1);
					send_address(addr_pool[idx], addr_len_pool[idx]);
				end else begin
					len = ($urandom_range(9) == 0) ? 8 : $urandom_range(6, 1);
					bytes = {$urandom, $urandom};
					if (addr_pool.size() >= POOL_SIZE) begin
						idx = $urandom_range(POOL_SIZE - 1);
						addr_pool[idx] = bytes;
						addr_len_pool[idx] = len;
					end else begin
						addr_pool.push_back(bytes);
						addr_len_pool.push_back(len);
					end
					send_address(bytes, len);
				end
			end
		end

		drain();
		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
